// File: hw/rtl/tfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfe_pkg
// Shared types, codes and symbol tables of the two-wire serial frame encoder.
// ----------------------------------------------------------------------------
package tfe_pkg;

    // Operation codes carried by an input word.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_PERIOD  = 2'd0;
    localparam logic [1:0] REG_SHORTEN = 2'd1;

    // Wire symbols: bit 0 is wire A, bit 1 is wire B.
    localparam logic [1:0] SYM_NONE = 2'b00;
    localparam logic [1:0] SYM_A    = 2'b01;
    localparam logic [1:0] SYM_B    = 2'b10;
    localparam logic [1:0] SYM_AB   = 2'b11;

    // Register reset values and sizes.
    localparam logic [11:0] PERIOD_RESET  = 12'd64;
    localparam logic [3:0]  SHORTEN_RESET = 4'd2;
    localparam int          TFE_QUEUE_DEPTH = 2;

    // Sequence lengths in symbols, counted from zero.
    localparam logic [3:0] START_IDLE_CNT = 4'd3;
    localparam logic [3:0] START_LAST     = 4'd12;
    localparam logic [3:0] END_LAST       = 4'd6;
    localparam logic [3:0] DATA_LAST      = 4'd7;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic        pin_a;
        logic        pin_b;
        logic [11:0] hold_ticks;
        logic        last;
    } out_word_t;

    // One queued command between the front and back sections.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } cmd_t;

    // Start pattern after the idle lead-in.
    function automatic logic [1:0] start_sym(input logic [3:0] idx);
        logic [1:0] s;
        case (idx)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd8: s = SYM_B;
            4'd9:                         s = SYM_AB;
            default:                      s = SYM_NONE;
        endcase
        return s;
    endfunction

    // Closing pattern of a packet.
    function automatic logic [1:0] end_sym(input logic [2:0] idx);
        logic [1:0] s;
        case (idx)
            3'd0, 3'd6:       s = SYM_AB;
            3'd1, 3'd3, 3'd5: s = SYM_A;
            default:          s = SYM_NONE;
        endcase
        return s;
    endfunction

endpackage : tfe_pkg
`default_nettype wire

// File: hw/rtl/tfe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfe_front
// Accepts input words, drops unknown operations and queues the rest.
// ----------------------------------------------------------------------------
module tfe_front import tfe_pkg::*; (
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output cmd_t          q_cmd
);

    logic known_op;

    // Classify the operation; an unknown code is taken and discarded.
    always_comb begin
        unique case (s_data.operation)
            OP_START, OP_DATA, OP_END: known_op = 1'b1;
            default:                   known_op = 1'b0;
        endcase
    end

    assign s_ready         = !q_full;
    assign q_push          = s_valid && !q_full && known_op;
    assign q_cmd.op        = s_data.operation;
    assign q_cmd.data_byte = s_data.data_byte;

endmodule : tfe_front
`default_nettype wire

// File: hw/rtl/tfe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfe_queue
// Small first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module tfe_queue import tfe_pkg::*; #(
    parameter int DEPTH = TFE_QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      q_valid,
    output logic      q_full,
    output cmd_t      q_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> count_reg != CW'(DEPTH))
        else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("command queue underflow");
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("command pushed into a full queue");
`endif

endmodule : tfe_queue
`default_nettype wire

// File: hw/rtl/tfe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfe_back
// Symbol sequencer: turns one queued command into its wire symbols, one
// symbol per clock unless m_ready stalls, through a registered output word.
// ----------------------------------------------------------------------------
module tfe_back import tfe_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [11:0] period_ticks,
    input  wire logic [3:0]  fast_shorten,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_data
);

    logic        busy_reg, busy_next;
    logic [1:0]  op_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  step_reg, step_next;
    logic [1:0]  line_reg, line_next;
    logic        m_valid_reg, m_valid_next;
    out_word_t   m_word_reg;

    logic [11:0] fast_hold;
    logic [3:0]  start_idx;
    logic        data_bit;
    logic [1:0]  pre_sym, main_sym;
    logic [1:0]  sym;
    logic [11:0] sym_hold;
    logic        sym_last;
    logic        sym_adv;
    logic        emit;

    // Shortened period, saturating at zero.
    assign fast_hold = (period_ticks > {8'd0, fast_shorten})
                     ? period_ticks - {8'd0, fast_shorten} : 12'd0;
    assign start_idx = step_reg - START_IDLE_CNT;

    // Data bit under the sequencer; even steps are A-clocked, odd B-clocked.
    assign data_bit = byte_reg[3'(4'd7 - step_reg)];

    always_comb begin
        if (!step_reg[0]) begin
            pre_sym  = data_bit ? SYM_AB : SYM_A;
            main_sym = data_bit ? SYM_B  : SYM_NONE;
        end else begin
            pre_sym  = data_bit ? SYM_AB : SYM_B;
            main_sym = data_bit ? SYM_A  : SYM_NONE;
        end
    end

    // Select the next symbol of the current command.
    always_comb begin
        sym      = SYM_AB;
        sym_hold = period_ticks;
        sym_last = 1'b1;
        sym_adv  = 1'b1;
        unique case (op_reg)
            OP_START: begin
                if (step_reg < START_IDLE_CNT) begin
                    sym = SYM_AB;
                end else begin
                    sym      = start_sym(start_idx);
                    sym_hold = fast_hold;
                end
                sym_last = (step_reg == START_LAST);
            end
            OP_END: begin
                sym      = end_sym(step_reg[2:0]);
                sym_last = (step_reg == END_LAST);
            end
            OP_DATA: begin
                // The clock edge symbol goes out first unless the wires already hold it.
                if (line_reg != pre_sym) begin
                    sym      = pre_sym;
                    sym_last = 1'b0;
                    sym_adv  = 1'b0;
                end else begin
                    sym      = main_sym;
                    sym_last = (step_reg == DATA_LAST);
                end
            end
            default: begin
                sym      = SYM_AB;
                sym_last = 1'b1;
            end
        endcase
    end

    assign emit  = busy_reg && (!m_valid_reg || m_ready);
    assign q_pop = q_valid && (!busy_reg || (emit && sym_last));

    // Sequencer control.
    always_comb begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        line_next    = line_reg;
        m_valid_next = m_valid_reg;
        if (emit) begin
            line_next    = sym;
            m_valid_next = 1'b1;
            if (sym_last) begin
                busy_next = 1'b0;
                step_next = '0;
            end else if (sym_adv) begin
                step_next = step_reg + 1'b1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            line_reg    <= SYM_AB;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            line_reg    <= line_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Command and output payload registers.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            op_reg   <= q_cmd.op;
            byte_reg <= q_cmd.data_byte;
        end
        if (emit) begin
            m_word_reg.pin_a      <= sym[0];
            m_word_reg.pin_b      <= sym[1];
            m_word_reg.hold_ticks <= sym_hold;
            m_word_reg.last       <= sym_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

`ifndef SYNTH
    a_line_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && emit |=> line_reg == $past(sym))
        else $error("line state does not follow the emitted symbol");
    a_stay_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && emit && !sym_last |=> busy_reg)
        else $error("sequencer dropped a command before its last symbol");
    a_data_step: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && op_reg == OP_DATA |-> step_reg <= DATA_LAST)
        else $error("data step counter out of range");
    a_start_step: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && op_reg == OP_START |-> step_reg <= START_LAST)
        else $error("start step counter out of range");
`endif

endmodule : tfe_back
`default_nettype wire

// File: hw/rtl/two_wire_serial_frame_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_wire_serial_frame_encoder
// Encodes start, data and end operations into symbols on two wires that
// take turns as clock and data.
// ----------------------------------------------------------------------------
// Each input word becomes a run of output words, one wire symbol each with
// its hold time: a start makes 13 symbols, an end 7, and a data byte 11 to 16
// depending on the bits and the current line levels; an unknown operation
// makes none. The back-end sequencer issues one symbol per clock while
// m_ready is high, and input words are taken every cycle while the command
// queue has room. Configuration registers are written through cfg_we;
// the user must do so only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module two_wire_serial_frame_encoder import tfe_pkg::*; #(
    parameter int QUEUE_DEPTH = TFE_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_word_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_wdata
);

    logic [11:0] period_reg;
    logic [3:0]  shorten_reg;
    logic        q_push, q_pop, q_valid, q_full;
    cmd_t        push_cmd, q_cmd;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= PERIOD_RESET;
            shorten_reg <= SHORTEN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PERIOD:  period_reg  <= cfg_wdata;
                REG_SHORTEN: shorten_reg <= cfg_wdata[3:0];
                default:     ;
            endcase
        end
    end

    tfe_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    tfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_cmd    (q_cmd)
    );

    tfe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .period_ticks (period_reg),
        .fast_shorten (shorten_reg),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule : two_wire_serial_frame_encoder
`default_nettype wire
